/* sv/assert_macros.svh */
// Assertion macros shared by the order book RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

/* sv/lob_pkg.sv */
// Shared types and codes for the limit order book.
// No dependencies; used by lob_cell and limit_order_matcher.
`timescale 1ns / 1ps
package lob_pkg;
  localparam int unsigned MAX_ORDERS_DEF = 32;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 6;

  localparam logic OP_NEW    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;
  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK, ST_BAD_FIELDS, ST_DUP_ID, ST_BOOK_FULL, ST_UNKNOWN_ID, ST_WRONG_OWNER
  } status_e;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SEARCH, S_REST} lob_state_e;

  typedef enum logic [1:0] {CELL_NOP, CELL_FILL, CELL_CLEAR, CELL_INSERT} cell_op_e;

  // best-so-far word passed down the cell chain
  typedef struct packed {
    logic               found;
    logic signed [31:0] price;
    logic [63:0]        arrival;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        id;
    logic [31:0]        owner;
    logic [31:0]        qty;
  } token_t;

  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   idx;
    logic               want_side;
    logic [31:0]        look_id;
    logic [31:0]        qty;
    logic [31:0]        id;
    logic [31:0]        owner;
    logic               side;
    logic signed [31:0] price;
    logic [63:0]        arrival;
  } cmd_t;
endpackage

/* sv/lob_cell.sv */
// One order slot of the book plus one stage of the best-order search chain.
// Depends on lob_pkg.
`timescale 1ns / 1ps
module lob_cell import lob_pkg::*; #(
  parameter int unsigned SLOT = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  token_t      tok_i,
  output token_t      tok_o,
  output logic        hit_o,
  output logic [31:0] owner_o,
  output logic        valid_o
);
  logic               valid_q, valid_d;
  logic [31:0]        id_q, owner_q, qty_q, qty_d;
  logic               side_q;
  logic signed [31:0] price_q;
  logic [63:0]        arrival_q;
  token_t             tok_q, tok_d;
  logic               sel, mine, better;

  assign sel = cmd_i.idx == IDX_W'(SLOT);
  assign mine = valid_q && (side_q == cmd_i.want_side);
  assign hit_o = valid_q && (id_q == cmd_i.look_id);
  assign owner_o = hit_o ? owner_q : '0;
  assign valid_o = valid_q;
  assign tok_o = tok_q;

  always_comb begin
    if (!tok_i.found) begin
      better = 1'b1;
    end else if (price_q != tok_i.price) begin
      better = (cmd_i.want_side == SIDE_SELL) ? (price_q < tok_i.price)
                                              : (price_q > tok_i.price);
    end else begin
      better = arrival_q < tok_i.arrival;
    end
    tok_d = tok_i;
    if (mine && better) begin
      tok_d.found   = 1'b1;
      tok_d.price   = price_q;
      tok_d.arrival = arrival_q;
      tok_d.idx     = IDX_W'(SLOT);
      tok_d.id      = id_q;
      tok_d.owner   = owner_q;
      tok_d.qty     = qty_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    qty_d = qty_q;
    if (sel) begin
      case (cmd_i.op)
        CELL_FILL: begin
          qty_d = qty_q - cmd_i.qty;
          if (qty_d == '0) valid_d = 1'b0;
        end
        CELL_CLEAR:  valid_d = 1'b0;
        CELL_INSERT: begin
          valid_d = 1'b1;
          qty_d = cmd_i.qty;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qty_q <= qty_d;
    if (sel && cmd_i.op == CELL_INSERT) begin
      id_q      <= cmd_i.id;
      owner_q   <= cmd_i.owner;
      side_q    <= cmd_i.side;
      price_q   <= cmd_i.price;
      arrival_q <= cmd_i.arrival;
    end
  end
endmodule

/* sv/limit_order_matcher.sv */
// Price-time priority limit order book over a row of MAX_ORDERS slot cells.
// Depends on lob_pkg, lob_cell and assert_macros.svh.
//
// Usage: drive a word on the input ports with start_i high; it is taken at a
// clock edge where busy_o is low. busy_o stays high until the item is done.
// Results appear on the result ports for one cycle each, marked by
// result_valid_o: zero or more trade words, then one done word with last_o.
// The receiver cannot stall; every result must be taken as it appears.
// Flow: the word is taken, id and field checks follow, then for a new order
// one or more searches of the opposite side, each made by the best-order word
// walking the cell chain one cell per cycle, then the rest step. A new order
// runs S searches before its done word, with S = F + 1 for F fills, or S = F
// when the last fill completes the order. Rejects and cancels give their done
// word in the cycle after the check. The next word can be taken in the cycle
// where the done word is out.
// Reset empties the book and clears the arrival counter at once; no
// clearing pass is needed, so start_i is taken right after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module limit_order_matcher import lob_pkg::*; #(
  parameter int unsigned MAX_ORDERS = MAX_ORDERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               operation_i,
  input  logic [31:0]        order_id_i,
  input  logic [31:0]        user_id_i,
  input  logic               side_i,
  input  logic signed [31:0] price_ticks_i,
  input  logic [31:0]        quantity_i,
  input  logic [63:0]        timestamp_i,
  output logic               result_valid_o,
  output logic               kind_o,
  output logic [2:0]         status_o,
  output logic [31:0]        taker_id_o,
  output logic [31:0]        maker_id_o,
  output logic [31:0]        buyer_user_o,
  output logic [31:0]        seller_user_o,
  output logic signed [31:0] trade_price_o,
  output logic [31:0]        trade_qty_o,
  output logic [63:0]        trade_time_o,
  output logic [CNT_W-1:0]   open_orders_o,
  output logic               last_o
);
  localparam int unsigned SCAN_W = $clog2(MAX_ORDERS + 1);

  lob_state_e         state_q, state_d;
  logic               op_q, side_q;
  logic [31:0]        id_q, user_q, qty_q, qty_d;
  logic signed [31:0] price_q;
  logic [63:0]        ts_q, arrival_q, arrival_d;
  logic [SCAN_W-1:0]  scan_q, scan_d;
  logic [CNT_W-1:0]   count_q, count_d;

  cmd_t               cmd;
  token_t             tok [MAX_ORDERS+1];
  token_t             tail;
  logic [MAX_ORDERS-1:0] hit, valid;
  logic [31:0]        owner [MAX_ORDERS];
  logic [IDX_W-1:0]   hit_idx, free_idx;
  logic [31:0]        hit_owner;
  logic               any_hit, any_free;

  logic               accept, bad_fields, owner_ok, scan_done, crosses;
  logic [31:0]        fill;

  // result word before the output register
  logic               emit, e_kind, e_last;
  status_e            e_status;
  logic [31:0]        e_maker, e_buyer, e_seller, e_qty;
  logic signed [31:0] e_price;

  assign tok[0] = '0;
  assign tail = tok[MAX_ORDERS];

  for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
    lob_cell #(.SLOT(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1]),
      .hit_o   (hit[i]),
      .owner_o (owner[i]),
      .valid_o (valid[i])
    );
  end

  // ids are unique among resting orders, so at most one cell hits
  always_comb begin
    hit_idx = '0;
    hit_owner = '0;
    free_idx = '0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (hit[i]) hit_idx = hit_idx | IDX_W'(i);
      hit_owner = hit_owner | owner[i];
    end
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = IDX_W'(i);
    end
  end

  assign any_hit = |hit;
  assign any_free = ~&valid;
  assign accept = start_i && !busy_o;
  assign busy_o = state_q != S_IDLE;
  assign bad_fields = (qty_q == '0) || (price_q <= 0);
  assign owner_ok = (user_q == '0) || (hit_owner == user_q);
  assign scan_done = scan_q == SCAN_W'(MAX_ORDERS);
  assign crosses = tail.found && ((side_q == SIDE_BUY) ? (tail.price <= price_q)
                                                       : (tail.price >= price_q));
  assign fill = (qty_q < tail.qty) ? qty_q : tail.qty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CHECK;
      S_CHECK: begin
        if (op_q == OP_CANCEL || bad_fields || any_hit) state_d = S_IDLE;
        else state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (scan_done) begin
          if (crosses && (qty_q - fill) != '0) state_d = S_SEARCH;
          else state_d = S_REST;
        end
      end
      S_REST:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.op = CELL_NOP;
    cmd.want_side = ~side_q;
    cmd.look_id = id_q;
    cmd.id = id_q;
    cmd.owner = user_q;
    cmd.side = side_q;
    cmd.price = price_q;
    cmd.arrival = arrival_q;
    qty_d = qty_q;
    count_d = count_q;
    arrival_d = arrival_q;
    scan_d = '0;
    emit = 1'b0;
    e_kind = KIND_DONE;
    e_last = 1'b1;
    e_status = ST_OK;
    e_maker = '0;
    e_buyer = '0;
    e_seller = '0;
    e_qty = '0;
    e_price = '0;
    case (state_q)
      S_CHECK: begin
        if (op_q == OP_CANCEL) begin
          emit = 1'b1;
          if (!any_hit) begin
            e_status = ST_UNKNOWN_ID;
          end else if (!owner_ok) begin
            e_status = ST_WRONG_OWNER;
          end else begin
            cmd.op = CELL_CLEAR;
            cmd.idx = hit_idx;
            count_d = count_q - 1'b1;
          end
        end else if (bad_fields) begin
          emit = 1'b1;
          e_status = ST_BAD_FIELDS;
        end else if (any_hit) begin
          emit = 1'b1;
          e_status = ST_DUP_ID;
        end
      end
      S_SEARCH: begin
        scan_d = scan_q + 1'b1;
        if (scan_done) begin
          scan_d = '0;
          if (crosses) begin
            cmd.op = CELL_FILL;
            cmd.idx = tail.idx;
            cmd.qty = fill;
            qty_d = qty_q - fill;
            if (tail.qty == fill) count_d = count_q - 1'b1;
            emit = 1'b1;
            e_kind = KIND_TRADE;
            e_last = 1'b0;
            e_maker = tail.id;
            e_buyer = (side_q == SIDE_BUY) ? user_q : tail.owner;
            e_seller = (side_q == SIDE_BUY) ? tail.owner : user_q;
            e_qty = fill;
            e_price = tail.price;
          end
        end
      end
      S_REST: begin
        emit = 1'b1;
        if (qty_q != '0) begin
          if (!any_free) begin
            e_status = ST_BOOK_FULL;
          end else begin
            cmd.op = CELL_INSERT;
            cmd.idx = free_idx;
            cmd.qty = qty_q;
            count_d = count_q + 1'b1;
            arrival_d = arrival_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q <= '0;
      count_q <= '0;
      arrival_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q <= scan_d;
      count_q <= count_d;
      arrival_q <= arrival_d;
      result_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      id_q    <= order_id_i;
      user_q  <= user_id_i;
      side_q  <= side_i;
      price_q <= price_ticks_i;
      qty_q   <= quantity_i;
      ts_q    <= timestamp_i;
    end else begin
      qty_q <= qty_d;
    end
    kind_o        <= e_kind;
    status_o      <= e_status;
    taker_id_o    <= (e_kind == KIND_TRADE) ? id_q : '0;
    maker_id_o    <= e_maker;
    buyer_user_o  <= e_buyer;
    seller_user_o <= e_seller;
    trade_price_o <= e_price;
    trade_qty_o   <= e_qty;
    trade_time_o  <= (e_kind == KIND_TRADE) ? ts_q : '0;
    open_orders_o <= count_d;
    last_o        <= e_last;
  end

  `ASSERT_CHK(a_done_frees, clk_i, rst_ni, $fell(busy_o) |-> result_valid_o && last_o)
  `ASSERT_CHK(a_trade_ok, clk_i, rst_ni,
              result_valid_o && (kind_o == KIND_TRADE) |-> (status_o == ST_OK) && !last_o)
  `ASSERT_NEVER(a_count_max, clk_i, rst_ni, count_q > CNT_W'(MAX_ORDERS))
endmodule
